/* rtl/lkv_pkg.sv */
// Shared types and constants for the size-aware LRU key-value cache.
package lkv_pkg;

  localparam int SIZE_BITS = 20;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [31:0] MAX_BYTES_RST = 32'd1048576;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam logic [2:0] SW_FIND   = 3'd0;
  localparam logic [2:0] SW_TOUCH  = 3'd1;
  localparam logic [2:0] SW_EVICT  = 3'd2;
  localparam logic [2:0] SW_DROP   = 3'd3;
  localparam logic [2:0] SW_INSERT = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] value_handle;
    logic [19:0] val_bytes;
    logic [31:0] life_secs;
    logic [63:0] now_ns;
  } lkv_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value_out;
    logic [19:0] size_out;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
    logic [6:0]  entries_used;
    logic [25:0] bytes_used;
  } lkv_out_t;

  typedef struct packed {
    logic       latch;
    logic       sweep_go;
    logic [2:0] sweep_mode;
    logic       drop_go;
    logic       write_go;
    logic       clear_go;
    logic       hit_inc;
    logic       miss_inc;
    logic       emit;
  } lkv_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       sweep_done;
    logic       found;
    logic       hit_ok;
    logic       over_cap;
    logic       cnt_zero;
    logic       full;
  } lkv_stat_t;

endpackage

/* rtl/lkv_ctrl.sv */
// Sequencer that steps each command through its search, eviction and update sweeps.
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lkv_pkg::lkv_stat_t stat,
  output lkv_pkg::lkv_cmd_t  cmd
);
  import lkv_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_GFIND  = 4'd2;
  localparam logic [3:0] S_GTOUCH = 4'd3;
  localparam logic [3:0] S_PCHK   = 4'd4;
  localparam logic [3:0] S_PEVICT = 4'd5;
  localparam logic [3:0] S_PFIND  = 4'd6;
  localparam logic [3:0] S_PFULL  = 4'd7;
  localparam logic [3:0] S_PTOUCH = 4'd8;
  localparam logic [3:0] S_PINS   = 4'd9;
  localparam logic [3:0] S_RFIND  = 4'd10;
  localparam logic [3:0] S_RDROP  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          OP_GET: begin
            cmd.sweep_go = 1'b1;
            cmd.sweep_mode = SW_FIND;
            state_nxt = S_GFIND;
          end
          OP_PUT: state_nxt = S_PCHK;
          OP_REMOVE: begin
            cmd.sweep_go = 1'b1;
            cmd.sweep_mode = SW_FIND;
            state_nxt = S_RFIND;
          end
          default: begin
            cmd.clear_go = 1'b1;
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_GFIND: begin
        if (stat.sweep_done) begin
          if (stat.hit_ok) begin
            cmd.sweep_go = 1'b1;
            cmd.sweep_mode = SW_TOUCH;
            state_nxt = S_GTOUCH;
          end else begin
            cmd.miss_inc = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_GTOUCH: begin
        if (stat.sweep_done) begin
          cmd.hit_inc = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_PCHK: begin
        cmd.sweep_go = 1'b1;
        if (stat.over_cap && !stat.cnt_zero) begin
          cmd.sweep_mode = SW_EVICT;
          state_nxt = S_PEVICT;
        end else begin
          cmd.sweep_mode = SW_FIND;
          state_nxt = S_PFIND;
        end
      end
      S_PEVICT: begin
        if (stat.sweep_done) begin
          state_nxt = S_PCHK;
        end
      end
      S_PFIND: begin
        if (stat.sweep_done) begin
          cmd.sweep_go = 1'b1;
          if (stat.found) begin
            cmd.sweep_mode = SW_TOUCH;
            state_nxt = S_PTOUCH;
          end else if (stat.full) begin
            cmd.sweep_mode = SW_EVICT;
            state_nxt = S_PFULL;
          end else begin
            cmd.sweep_mode = SW_INSERT;
            state_nxt = S_PINS;
          end
        end
      end
      S_PFULL: begin
        if (stat.sweep_done) begin
          cmd.sweep_go = 1'b1;
          cmd.sweep_mode = SW_INSERT;
          state_nxt = S_PINS;
        end
      end
      S_PTOUCH, S_PINS: begin
        if (stat.sweep_done) begin
          cmd.write_go = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_RFIND: begin
        if (stat.sweep_done) begin
          if (stat.found) begin
            cmd.drop_go = 1'b1;
            cmd.sweep_go = 1'b1;
            cmd.sweep_mode = SW_DROP;
            state_nxt = S_RDROP;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_RDROP: begin
        if (stat.sweep_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/lkv_dp.sv */
// Slot memories, sweep engine, totals and result register of the cache.
module lkv_dp #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lkv_pkg::lkv_in_t   in_word,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  lkv_pkg::lkv_cmd_t  cmd,
  output lkv_pkg::lkv_stat_t stat,
  output logic               out_strobe,
  output lkv_pkg::lkv_out_t  out_word
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int BW = SIZE_BITS + CW;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [63:0]        key_mem  [ENTRIES];
  logic [63:0]        val_mem  [ENTRIES];
  logic [19:0]        size_mem [ENTRIES];
  logic [63:0]        exp_mem  [ENTRIES];
  logic [IW-1:0]      rank_mem [ENTRIES];

  logic [ENTRIES-1:0] valid_r;
  logic [BW-1:0]      bt_r;
  logic [CW-1:0]      cnt_r;
  logic [31:0]        hit_r, miss_r, evict_r, max_bytes_r;
  logic               running_r, d_vld_r, d_last_r, done_r;
  logic               found_r, free_found_r, out_strobe_r;
  logic [2:0]         mode_r;
  logic [IW-1:0]      rd_idx_r, d_idx_r, s_r, free_r, tgt_r;
  logic [IW-1:0]      rank_s_r;
  logic [19:0]        size_s_r;
  logic [63:0]        val_s_r, exp_s_r, exp_r;
  logic [61:0]        span_r;
  lkv_in_t            in_r;
  lkv_out_t           out_r;

  logic [63:0]   key_q, val_q, exp_q;
  logic [19:0]   size_q;
  logic [IW-1:0] rank_q;
  logic          valid_q, key_hit, evict_hit, free_hit, hit_ok;
  logic          rank_we;
  logic [IW-1:0] rank_wa, rank_wd, wa;
  logic [64:0]   exp_sum;
  logic [1:0]    status;

  assign valid_q   = valid_r[d_idx_r];
  assign key_hit   = d_vld_r && (mode_r == SW_FIND) && valid_q && (key_q == in_r.key);
  assign evict_hit = d_vld_r && (mode_r == SW_EVICT) && valid_q && (rank_q == tgt_r);
  assign free_hit  = d_vld_r && (mode_r == SW_INSERT) && !valid_q && !free_found_r;
  assign hit_ok    = found_r && !((exp_s_r != 64'd0) && (in_r.now_ns > exp_s_r));
  assign wa        = found_r ? s_r : free_r;

  always_comb begin
    rank_we = 1'b0;
    rank_wa = d_idx_r;
    rank_wd = rank_q;
    if (cmd.write_go) begin
      rank_we = !found_r;
      rank_wa = free_r;
      rank_wd = '0;
    end else if (d_vld_r) begin
      unique case (mode_r)
        SW_TOUCH: begin
          if (d_idx_r == s_r) begin
            rank_we = 1'b1;
            rank_wd = '0;
          end else if (valid_q && (rank_q < rank_s_r)) begin
            rank_we = 1'b1;
            rank_wd = rank_q + 1'b1;
          end
        end
        SW_DROP: begin
          if (valid_q && (rank_q > rank_s_r)) begin
            rank_we = 1'b1;
            rank_wd = rank_q - 1'b1;
          end
        end
        SW_INSERT: begin
          if (valid_q) begin
            rank_we = 1'b1;
            rank_wd = rank_q + 1'b1;
          end
        end
        default: rank_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= key_mem[rd_idx_r];
    val_q  <= val_mem[rd_idx_r];
    size_q <= size_mem[rd_idx_r];
    exp_q  <= exp_mem[rd_idx_r];
    rank_q <= rank_mem[rd_idx_r];
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    if (cmd.write_go) begin
      val_mem[wa]  <= in_r.value_handle;
      size_mem[wa] <= in_r.val_bytes;
      exp_mem[wa]  <= exp_r;
      if (!found_r) begin
        key_mem[wa] <= in_r.key;
      end
    end
  end

  assign exp_sum = {1'b0, in_r.now_ns} + {3'b000, span_r};

  always_ff @(posedge clk) begin
    span_r <= 62'(in_r.life_secs) * 62'(NS_PER_SEC);
    if (in_r.life_secs == 32'd0) begin
      exp_r <= '0;
    end else if (exp_sum[64]) begin
      exp_r <= '1;
    end else begin
      exp_r <= exp_sum[63:0];
    end
    d_idx_r  <= rd_idx_r;
    d_last_r <= (rd_idx_r == LAST);
    if (cmd.latch) begin
      in_r <= in_word;
    end
    if (cmd.sweep_go) begin
      mode_r <= cmd.sweep_mode;
      tgt_r  <= IW'(cnt_r - 1'b1);
    end
    if (key_hit) begin
      s_r      <= d_idx_r;
      rank_s_r <= rank_q;
      size_s_r <= size_q;
      val_s_r  <= val_q;
      exp_s_r  <= exp_q;
    end
    if (free_hit) begin
      free_r <= d_idx_r;
    end
    if (cmd.emit) begin
      out_r.status       <= status;
      out_r.value_out    <= (in_r.opcode == OP_GET && hit_ok) ? val_s_r : 64'd0;
      out_r.size_out     <= (in_r.opcode == OP_GET && hit_ok) ? size_s_r : 20'd0;
      out_r.hit_total    <= hit_r;
      out_r.miss_total   <= miss_r;
      out_r.evict_total  <= evict_r;
      out_r.entries_used <= 7'(cnt_r);
      out_r.bytes_used   <= 26'(bt_r);
    end
  end

  always_comb begin
    unique case (in_r.opcode)
      OP_GET:    status = hit_ok ? ST_OK : ST_MISS;
      OP_REMOVE: status = found_r ? ST_OK : ST_ABSENT;
      default:   status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      bt_r         <= '0;
      cnt_r        <= '0;
      hit_r        <= '0;
      miss_r       <= '0;
      evict_r      <= '0;
      max_bytes_r  <= MAX_BYTES_RST;
      running_r    <= 1'b0;
      d_vld_r      <= 1'b0;
      done_r       <= 1'b0;
      rd_idx_r     <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      done_r       <= d_vld_r && d_last_r;
      d_vld_r      <= running_r;
      if (cfg_we) begin
        max_bytes_r <= cfg_data;
      end
      if (cmd.sweep_go) begin
        running_r    <= 1'b1;
        rd_idx_r     <= '0;
        free_found_r <= 1'b0;
        if (cmd.sweep_mode == SW_FIND) begin
          found_r <= 1'b0;
        end
      end else if (running_r) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        if (rd_idx_r == LAST) begin
          running_r <= 1'b0;
        end
      end
      if (key_hit) begin
        found_r <= 1'b1;
      end
      if (free_hit) begin
        free_found_r <= 1'b1;
      end
      if (evict_hit) begin
        valid_r[d_idx_r] <= 1'b0;
        bt_r  <= bt_r - BW'(size_q);
        cnt_r <= cnt_r - 1'b1;
        if (evict_r != '1) begin
          evict_r <= evict_r + 1'b1;
        end
      end
      if (cmd.drop_go) begin
        valid_r[s_r] <= 1'b0;
        bt_r  <= bt_r - BW'(size_s_r);
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.write_go) begin
        if (found_r) begin
          bt_r <= bt_r - BW'(size_s_r) + BW'(in_r.val_bytes);
        end else begin
          valid_r[free_r] <= 1'b1;
          bt_r  <= bt_r + BW'(in_r.val_bytes);
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.clear_go) begin
        valid_r <= '0;
        bt_r    <= '0;
        cnt_r   <= '0;
      end
      if (cmd.hit_inc && hit_r != '1) begin
        hit_r <= hit_r + 1'b1;
      end
      if (cmd.miss_inc && miss_r != '1) begin
        miss_r <= miss_r + 1'b1;
      end
    end
  end

  assign stat.op         = in_r.opcode;
  assign stat.sweep_done = done_r;
  assign stat.found      = found_r;
  assign stat.hit_ok     = hit_ok;
  assign stat.over_cap   = (33'(bt_r) + 33'(in_r.val_bytes)) > 33'(max_bytes_r);
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.full       = (cnt_r == CW'(ENTRIES));

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(cnt_r))
    else $error("entry count differs from valid slots");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (bt_r == '0))
    else $error("bytes held with no entries");

  a_done_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !running_r && $past(d_vld_r))
    else $error("sweep done without a finished pass");

  a_insert_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_go && !found_r) |-> free_found_r)
    else $error("insert without a free slot");

endmodule

/* rtl/size_aware_lru_kv_cache_core.sv */
// Top level of the size-aware LRU key-value cache.
// Commands run one at a time; every sweep walks all ENTRIES slots, one slot per cycle through
// the slot memories. A get runs a find sweep and, on a hit, a touch sweep; a remove runs a
// find sweep and, for a present key, a drop sweep; a clear runs no sweep; and a put runs one
// eviction sweep per entry evicted for capacity, a find sweep, an eviction sweep when a new
// key meets a full table, and then a touch or insert sweep.
// busy drops in the out_strobe cycle, so the next start is taken at the edge that ends it;
// the receiver cannot stall the result word.
module size_aware_lru_kv_cache_core #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lkv_pkg::lkv_in_t  in_word,
  output logic              out_strobe,
  output lkv_pkg::lkv_out_t out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import lkv_pkg::*;

  lkv_cmd_t  cmd;
  lkv_stat_t stat;

  assign cfg_ready = !busy;

  lkv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lkv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

/* tb/tb.sv */
// Self-checking regression for the size-aware LRU key-value cache core.
`timescale 1ns / 1ps

module tb;
  import lkv_pkg::*;

  localparam int SLOTS = 64;

  class cache_scoreboard;
    logic [31:0] cap_bytes;
    bit          live [SLOTS];
    logic [63:0] skey [SLOTS];
    logic [63:0] sval [SLOTS];
    logic [19:0] ssize [SLOTS];
    logic [63:0] sexp [SLOTS];
    int          rank [SLOTS];
    logic [25:0] bytes;
    int          count;
    logic [31:0] hits, misses, evicts;
    lkv_out_t    pending [$];
    int          errors;

    function void wipe();
      foreach (live[i]) live[i] = 0;
      cap_bytes = MAX_BYTES_RST;
      bytes = 0; count = 0; hits = 0; misses = 0; evicts = 0;
      pending.delete(); errors = 0;
    endfunction

    function int lookup(logic [63:0] k);
      for (int i = 0; i < SLOTS; i++) if (live[i] && skey[i] == k) return i;
      return -1;
    endfunction

    function void promote(int s);
      for (int i = 0; i < SLOTS; i++) if (live[i] && rank[i] < rank[s]) rank[i]++;
      rank[s] = 0;
    endfunction

    function void discard(int s);
      live[s] = 0;
      for (int i = 0; i < SLOTS; i++) if (live[i] && rank[i] > rank[s]) rank[i]--;
      bytes = bytes - ssize[s];
      if (count > 0) count--;
    endfunction

    function void evict_lru();
      int b;
      b = -1;
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && (b < 0 || rank[i] > rank[b])) b = i;
      if (b < 0) return;
      discard(b);
      if (evicts != 32'hFFFF_FFFF) evicts++;
    endfunction

    function void note_cmd(lkv_in_t w);
      lkv_out_t r;
      int s;
      logic [63:0] span;
      r = '0;
      case (w.opcode)
        OP_GET: begin
          s = lookup(w.key);
          if (s >= 0 && !(sexp[s] != 0 && w.now_ns > sexp[s])) begin
            promote(s);
            if (hits != 32'hFFFF_FFFF) hits++;
            r.value_out = sval[s];
            r.size_out = ssize[s];
          end else begin
            if (misses != 32'hFFFF_FFFF) misses++;
            r.status = ST_MISS;
          end
        end
        OP_PUT: begin
          while ({32'd0, bytes} + w.val_bytes > {32'd0, cap_bytes} && count > 0) evict_lru();
          s = lookup(w.key);
          if (s >= 0) begin
            bytes = bytes - ssize[s] + w.val_bytes;
            promote(s);
          end else begin
            if (count >= SLOTS) evict_lru();
            s = 0;
            for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) s = i;
            for (int i = 0; i < SLOTS; i++) if (live[i]) rank[i]++;
            live[s] = 1; rank[s] = 0; skey[s] = w.key;
            bytes = bytes + w.val_bytes;
            count++;
          end
          sval[s] = w.value_handle;
          ssize[s] = w.val_bytes;
          span = 64'(w.life_secs) * 64'd1000000000;
          if (w.life_secs == 0) sexp[s] = 0;
          else if (w.now_ns > ~span) sexp[s] = '1;
          else sexp[s] = w.now_ns + span;
        end
        OP_REMOVE: begin
          s = lookup(w.key);
          if (s >= 0) discard(s);
          else r.status = ST_ABSENT;
        end
        default: begin
          foreach (live[i]) live[i] = 0;
          bytes = 0; count = 0;
        end
      endcase
      r.hit_total = hits; r.miss_total = misses; r.evict_total = evicts;
      r.entries_used = 7'(count); r.bytes_used = bytes;
      pending.push_back(r);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endfunction

    function void check_word(lkv_out_t got);
      lkv_out_t e;
      if (pending.size() == 0) begin
        report("unexpected result word", '0, '0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) report("status", got.status, e.status);
      if (got.value_out !== e.value_out) report("value_out", got.value_out, e.value_out);
      if (got.size_out !== e.size_out) report("size_out", got.size_out, e.size_out);
      if (got.hit_total !== e.hit_total) report("hit_total", got.hit_total, e.hit_total);
      if (got.miss_total !== e.miss_total) report("miss_total", got.miss_total, e.miss_total);
      if (got.evict_total !== e.evict_total)
        report("evict_total", got.evict_total, e.evict_total);
      if (got.entries_used !== e.entries_used)
        report("entries_used", got.entries_used, e.entries_used);
      if (got.bytes_used !== e.bytes_used) report("bytes_used", got.bytes_used, e.bytes_used);
    endfunction
  endclass

  logic        clk, rst_n, start, busy, out_strobe, cfg_valid, cfg_ready;
  lkv_in_t     in_word;
  lkv_out_t    out_word;
  logic [31:0] cfg_data;
  cache_scoreboard sb;
  logic [63:0] key_pool [8];
  logic [63:0] clock_ns;

  size_aware_lru_kv_cache_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("size_aware_lru_kv_cache_core regression: fail");
    $finish;
  end

  always @(posedge clk) if (rst_n && out_strobe) sb.check_word(out_word);

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_cmd(lkv_in_t w);
    start <= 1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_cmd(w);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cap(logic [31:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.cap_bytes = v;
    cfg_valid <= 0;
  endtask

  function automatic lkv_in_t make_cmd(logic [1:0] op, logic [63:0] k, logic [19:0] sz,
                                       logic [31:0] ttl, logic [63:0] now);
    lkv_in_t w;
    w.opcode = op; w.key = k; w.val_bytes = sz; w.life_secs = ttl; w.now_ns = now;
    w.value_handle = {$urandom, $urandom};
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_cmd(bit tiny);
    lkv_in_t w;
    int p;
    p = $urandom_range(0, 99);
    w = make_cmd(2'(p < 40 ? OP_PUT : p < 75 ? OP_GET : p < 95 ? OP_REMOVE : OP_CLEAR),
                 $urandom_range(0, 5) == 0 ? rand64() : key_pool[$urandom_range(0, 7)],
                 tiny ? 20'($urandom_range(0, 300)) : 20'($urandom),
                 $urandom_range(0, 2) == 0 ? 32'd0 :
                 $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(1, 3)),
                 clock_ns);
    if (p == 99) w.opcode = OP_CLEAR;
    if ($urandom_range(0, 30) == 0) w.now_ns = rand64();
    else clock_ns = clock_ns + 64'($urandom_range(0, 800000000));
    send_cmd(w);
    idle_gap();
  endtask

  initial begin
    logic [31:0] caps [5];
    sb = new();
    sb.wipe();
    rst_n = 0; start = 0; cfg_valid = 0; cfg_data = '0; in_word = '0;
    clock_ns = 64'd1000;
    for (int i = 0; i < 8; i++) key_pool[i] = rand64();
    key_pool[0] = '0; key_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_cmd(make_cmd(OP_GET, '0, '0, '0, '0));
    send_cmd(make_cmd(OP_REMOVE, '1, '0, '0, '0));
    send_cmd(make_cmd(OP_PUT, '0, 20'hFFFFF, '0, '0));
    send_cmd(make_cmd(OP_PUT, '1, 20'd0, 32'hFFFF_FFFF, '1));
    send_cmd(make_cmd(OP_GET, '1, '0, '0, '1));
    send_cmd(make_cmd(OP_PUT, 64'd5, 20'd7, 32'd1, 64'd100));
    send_cmd(make_cmd(OP_GET, 64'd5, '0, '0, 64'd1000000100));
    send_cmd(make_cmd(OP_GET, 64'd5, '0, '0, 64'd1000000101));
    send_cmd(make_cmd(OP_PUT, 64'd5, 20'd9, 32'd0, 64'd2000000000));
    send_cmd(make_cmd(OP_GET, 64'd5, '0, '0, '1));
    send_cmd(make_cmd(OP_PUT, 64'd6, 20'hFFFFF, 32'd2, '0));
    send_cmd(make_cmd(OP_REMOVE, 64'd5, '0, '0, '0));
    send_cmd(make_cmd(OP_REMOVE, 64'd5, '0, '0, '0));
    send_cmd(make_cmd(OP_CLEAR, '1, 20'hFFFFF, '1, '1));
    for (int i = 0; i < 66; i++) send_cmd(make_cmd(OP_PUT, 64'(i), 20'd3, '0, '0));
    send_cmd(make_cmd(OP_GET, 64'd0, '0, '0, '0));
    send_cmd(make_cmd(OP_GET, 64'd65, '0, '0, '0));
    drain();

    caps[0] = 32'd0; caps[1] = 32'hFFFF_FFFF; caps[2] = 32'd1000;
    caps[3] = 32'd3000000; caps[4] = MAX_BYTES_RST;
    for (int ph = 0; ph < 5; ph++) begin
      write_cap(caps[ph]);
      for (int n = 0; n < 200; n++) random_cmd(ph == 2);
      if (ph == 1) begin
        for (int n = 0; n < 70; n++) begin
          send_cmd(make_cmd(OP_PUT, rand64(), 20'($urandom), '0, '0));
        end
        drain();
      end
    end
    write_cap(32'd1200);
    for (int n = 0; n < 300; n++) random_cmd(1);

    drain();
    if (sb.errors == 0) $display("size_aware_lru_kv_cache_core regression: pass");
    else $display("size_aware_lru_kv_cache_core regression: fail");
    $finish;
  end

endmodule
